// ----- design/tws_pkg.sv -----
`timescale 1ns / 1ps

package tws_pkg;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_SEL   = 3'd1;
  localparam logic [2:0] PH_OPC   = 3'd2;
  localparam logic [2:0] PH_DAT   = 3'd3;
  localparam logic [2:0] PH_DESEL = 3'd4;

  localparam logic [2:0] MODE_NONE = 3'd0;
  localparam logic [2:0] MODE_WR8  = 3'd1;
  localparam logic [2:0] MODE_WR9  = 3'd2;
  localparam logic [2:0] MODE_RD8  = 3'd3;
  localparam logic [2:0] MODE_RD9  = 3'd4;

  localparam logic [15:0] HALF_RESET   = 16'd5;
  localparam logic [3:0]  OPCODE_BITS  = 4'd8;
  localparam logic [3:0]  SHORT_BITS   = 4'd8;
  localparam logic [3:0]  LONG_BITS    = 4'd9;

  typedef struct packed {
    logic       cmd;
    logic [7:0] opcode;
    logic [2:0] data_mode;
    logic [8:0] write_data;
    logic       dq_in;
  } tws_in_t;

  typedef struct packed {
    logic       rst_pin;
    logic       clk_pin;
    logic       dq_out;
    logic       dq_drive;
    logic       busy_res;
    logic       done_res;
    logic [8:0] read_data;
    logic       start_ignored;
  } tws_out_t;

endpackage

// ----- design/three_wire_serial_master.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  tws_in_t, one tick word
// out_      output     out_valid/out_stall  tws_out_t, pin levels and status
// cfg_      input      cfg_we               cfg_wdata, half period in ticks
//
// Every accepted word is one tick and yields one result word in the following cycle.
// A new word is accepted in every cycle unless in_stall is high; the output register is the only stage.
// in_stall is high only while a result waits in the output register and out_stall is high.
// Synchronous active-low reset returns the bus to idle with a half period of 5 ticks.

module three_wire_serial_master (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tws_pkg::tws_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tws_pkg::tws_out_t out_data,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata
);
  import tws_pkg::*;

  logic [15:0] half_r;
  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  bit_index_r, bit_index_nxt;
  logic        bit_half_r, bit_half_nxt;
  logic [15:0] wait_count_r, wait_count_nxt;
  logic [2:0]  mode_held_r, mode_held_nxt;
  logic [7:0]  opcode_held_r, opcode_held_nxt;
  logic [8:0]  out_shift_r, out_shift_nxt;
  logic [8:0]  in_shift_r, in_shift_nxt;
  logic        out_valid_r;
  tws_out_t    out_data_r, out_data_nxt;

  logic        accept;
  logic [15:0] half_eff;
  logic [15:0] wait_inc;
  logic [3:0]  index_inc;
  logic        reads_cur;
  logic        long_cur;
  logic        has_data_cur;
  logic        reads_nxt;
  logic        done;
  logic        ignored;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign half_eff     = (half_r == 16'd0) ? 16'd1 : half_r;
  assign wait_inc     = wait_count_r + 16'd1;
  assign index_inc    = bit_index_r + 4'd1;
  assign reads_cur    = (mode_held_r == MODE_RD8) || (mode_held_r == MODE_RD9);
  assign long_cur     = (mode_held_r == MODE_WR9) || (mode_held_r == MODE_RD9);
  assign has_data_cur = (mode_held_r >= MODE_WR8) && (mode_held_r <= MODE_RD9);
  assign reads_nxt    = (mode_held_nxt == MODE_RD8) || (mode_held_nxt == MODE_RD9);

  always_comb begin
    phase_nxt       = phase_r;
    bit_index_nxt   = bit_index_r;
    bit_half_nxt    = bit_half_r;
    wait_count_nxt  = wait_count_r;
    mode_held_nxt   = mode_held_r;
    opcode_held_nxt = opcode_held_r;
    out_shift_nxt   = out_shift_r;
    in_shift_nxt    = in_shift_r;
    done            = 1'b0;
    ignored         = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (in_data.cmd) begin
        opcode_held_nxt = in_data.opcode;
        mode_held_nxt   = in_data.data_mode;
        out_shift_nxt   = in_data.write_data;
        in_shift_nxt    = 9'd0;
        phase_nxt       = PH_SEL;
        bit_index_nxt   = 4'd0;
        bit_half_nxt    = 1'b0;
        wait_count_nxt  = 16'd0;
      end
    end else begin
      ignored = in_data.cmd;
      if (wait_inc != 16'd0 && wait_inc < half_eff) begin
        wait_count_nxt = wait_inc;
      end else begin
        wait_count_nxt = 16'd0;
        unique case (phase_r)
          PH_SEL: begin
            phase_nxt     = PH_OPC;
            bit_index_nxt = 4'd0;
            bit_half_nxt  = 1'b0;
          end
          PH_OPC: begin
            if (!bit_half_r) begin
              bit_half_nxt = 1'b1;
            end else begin
              bit_half_nxt  = 1'b0;
              bit_index_nxt = index_inc;
              if (index_inc >= OPCODE_BITS) begin
                bit_index_nxt = 4'd0;
                phase_nxt     = has_data_cur ? PH_DAT : PH_DESEL;
              end
            end
          end
          PH_DAT: begin
            if (!bit_half_r) begin
              bit_half_nxt = 1'b1;
            end else begin
              if (reads_cur && in_data.dq_in && bit_index_r < LONG_BITS) begin
                in_shift_nxt = in_shift_r | (9'd1 << bit_index_r);
              end
              bit_half_nxt  = 1'b0;
              bit_index_nxt = index_inc;
              if (index_inc >= (long_cur ? LONG_BITS : SHORT_BITS)) begin
                bit_index_nxt = 4'd0;
                phase_nxt     = PH_DESEL;
              end
            end
          end
          PH_DESEL: begin
            phase_nxt     = PH_IDLE;
            bit_index_nxt = 4'd0;
            bit_half_nxt  = 1'b0;
            done          = 1'b1;
          end
          default: begin
            phase_nxt     = PH_IDLE;
            bit_index_nxt = 4'd0;
            bit_half_nxt  = 1'b0;
          end
        endcase
      end
    end
  end

  always_comb begin
    out_data_nxt               = '0;
    out_data_nxt.clk_pin       = 1'b1;
    out_data_nxt.busy_res      = (phase_nxt != PH_IDLE);
    out_data_nxt.done_res      = done;
    out_data_nxt.read_data     = in_shift_nxt;
    out_data_nxt.start_ignored = ignored;
    unique case (phase_nxt) inside
      PH_SEL, PH_DESEL: begin
        out_data_nxt.rst_pin = 1'b1;
      end
      PH_OPC: begin
        out_data_nxt.rst_pin = 1'b1;
        if (!bit_half_nxt) begin
          out_data_nxt.clk_pin  = 1'b0;
          out_data_nxt.dq_drive = 1'b1;
          out_data_nxt.dq_out   = opcode_held_nxt[bit_index_nxt[2:0]];
        end
      end
      PH_DAT: begin
        out_data_nxt.rst_pin = 1'b1;
        if (reads_nxt) begin
          out_data_nxt.clk_pin = !bit_half_nxt;
        end else if (!bit_half_nxt) begin
          out_data_nxt.clk_pin  = 1'b0;
          out_data_nxt.dq_drive = 1'b1;
          out_data_nxt.dq_out   = (bit_index_nxt < LONG_BITS) ?
                                  out_shift_nxt[bit_index_nxt] : 1'b0;
        end
      end
      default: begin
        out_data_nxt.rst_pin = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= HALF_RESET;
    end else if (cfg_we) begin
      half_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      bit_index_r   <= 4'd0;
      bit_half_r    <= 1'b0;
      wait_count_r  <= 16'd0;
      mode_held_r   <= MODE_NONE;
      opcode_held_r <= 8'd0;
      out_shift_r   <= 9'd0;
      in_shift_r    <= 9'd0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      bit_index_r   <= bit_index_nxt;
      bit_half_r    <= bit_half_nxt;
      wait_count_r  <= wait_count_nxt;
      mode_held_r   <= mode_held_nxt;
      opcode_held_r <= opcode_held_nxt;
      out_shift_r   <= out_shift_nxt;
      in_shift_r    <= in_shift_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ----- design/tws_checker.sv -----
`timescale 1ns / 1ps

module tws_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input tws_pkg::tws_out_t out_data
);

  // A held result word must not change while the receiver stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // The input side can only be held back by a waiting result word.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result word");

  // An idle bus leaves select low, clock high and data released.
  a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.busy_res |->
      !out_data.rst_pin && out_data.clk_pin && !out_data.dq_drive)
    else $error("pins not at idle levels while not busy");

  // Completion is reported with select already dropped.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res && !out_data.rst_pin)
    else $error("done reported while transaction still active");

  // The data level is zero whenever the line is released.
  a_dq_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.dq_drive |-> !out_data.dq_out)
    else $error("data level set while line released");

endmodule

bind three_wire_serial_master tws_checker u_tws_checker (.*);

// ----- bench/tb_three_wire_serial_master.sv -----
`timescale 1ns / 1ps

module tb_three_wire_serial_master;
  import tws_pkg::*;

  localparam int LIMIT_NS = 1_000_000;

  localparam int DQ_LOW    = 0;
  localparam int DQ_HIGH   = 1;
  localparam int DQ_RANDOM = 2;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  tws_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  tws_out_t    out_data;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  three_wire_serial_master DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Bus model state, updated on every accepted tick word.
  logic [2:0]  bus_phase;
  logic [3:0]  bit_pos;
  logic        half_sel;
  logic [15:0] tick_count;
  logic [2:0]  mode_q;
  logic [7:0]  opc_q;
  logic [8:0]  wr_word;
  logic [8:0]  rd_word;
  logic [15:0] half_ticks;

  tws_out_t pin_words[$];

  int mismatches     = 0;
  int words_seen     = 0;
  int ticks_taken    = 0;
  int ticks_sent     = 0;
  int starts_taken   = 0;
  int starts_refused = 0;
  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int cur_half       = HALF_RESET;

  function automatic int data_bits(input logic [2:0] mode);
    if (mode == MODE_WR8 || mode == MODE_RD8) return SHORT_BITS;
    if (mode == MODE_WR9 || mode == MODE_RD9) return LONG_BITS;
    return 0;
  endfunction

  function automatic logic advance_bus(input logic dq);
    logic [15:0] h;
    logic        reads;
    h = (half_ticks == 16'd0) ? 16'd1 : half_ticks;
    reads = (mode_q == MODE_RD8) || (mode_q == MODE_RD9);
    if (bus_phase == PH_IDLE) return 1'b0;
    tick_count = tick_count + 16'd1;
    if (tick_count != 16'd0 && tick_count < h) return 1'b0;
    tick_count = '0;
    case (bus_phase)
      PH_SEL: begin
        bus_phase = PH_OPC;
        bit_pos = '0;
        half_sel = 1'b0;
      end
      PH_OPC: begin
        if (!half_sel) begin
          half_sel = 1'b1;
        end else begin
          half_sel = 1'b0;
          bit_pos = bit_pos + 4'd1;
          if (bit_pos >= OPCODE_BITS) begin
            bit_pos = '0;
            bus_phase = (data_bits(mode_q) != 0) ? PH_DAT : PH_DESEL;
          end
        end
      end
      PH_DAT: begin
        if (!half_sel) begin
          half_sel = 1'b1;
        end else begin
          if (reads && dq && bit_pos < LONG_BITS) rd_word[bit_pos] = 1'b1;
          half_sel = 1'b0;
          bit_pos = bit_pos + 4'd1;
          if (bit_pos >= data_bits(mode_q)) begin
            bit_pos = '0;
            bus_phase = PH_DESEL;
          end
        end
      end
      PH_DESEL: begin
        bus_phase = PH_IDLE;
        bit_pos = '0;
        half_sel = 1'b0;
        return 1'b1;
      end
      default: begin
        bus_phase = PH_IDLE;
        bit_pos = '0;
        half_sel = 1'b0;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic tws_out_t predict_tick(input tws_in_t w);
    tws_out_t r;
    logic     reads;
    r = '0;
    r.clk_pin = 1'b1;
    if (bus_phase == PH_IDLE) begin
      if (w.cmd) begin
        opc_q = w.opcode;
        mode_q = w.data_mode;
        wr_word = w.write_data;
        rd_word = '0;
        bus_phase = PH_SEL;
        bit_pos = '0;
        half_sel = 1'b0;
        tick_count = '0;
        starts_taken++;
      end
    end else begin
      r.start_ignored = w.cmd;
      starts_refused += w.cmd;
      r.done_res = advance_bus(w.dq_in);
    end
    reads = (mode_q == MODE_RD8) || (mode_q == MODE_RD9);
    case (bus_phase) inside
      PH_SEL, PH_DESEL: r.rst_pin = 1'b1;
      PH_OPC: begin
        r.rst_pin = 1'b1;
        if (!half_sel) begin
          r.clk_pin = 1'b0;
          r.dq_drive = 1'b1;
          r.dq_out = opc_q[bit_pos[2:0]];
        end
      end
      PH_DAT: begin
        r.rst_pin = 1'b1;
        if (reads) begin
          r.clk_pin = !half_sel;
        end else if (!half_sel) begin
          r.clk_pin = 1'b0;
          r.dq_drive = 1'b1;
          r.dq_out = (bit_pos < LONG_BITS) ? wr_word[bit_pos] : 1'b0;
        end
      end
      default: ;
    endcase
    r.busy_res = (bus_phase != PH_IDLE);
    r.read_data = rd_word;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [8:0] got,
                                 input logic [8:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t: word %0d %s: got 0x%0h, expected 0x%0h", $time, words_seen, what, got,
               want);
  endtask

  always @(posedge clk) begin : monitor
    tws_out_t want;
    if (!rst_n) begin
      half_ticks = HALF_RESET;
      bus_phase = PH_IDLE;
      bit_pos = '0;
      half_sel = 1'b0;
      tick_count = '0;
      mode_q = '0;
      opc_q = '0;
      wr_word = '0;
      rd_word = '0;
      pin_words.delete();
    end else begin
      if (cfg_we) half_ticks = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (pin_words.size() == 0) begin
          report_mismatch("arrived with none expected, read_data", out_data.read_data, '0);
        end else begin
          want = pin_words.pop_front();
          if (out_data.rst_pin !== want.rst_pin)
            report_mismatch("rst_pin", out_data.rst_pin, want.rst_pin);
          if (out_data.clk_pin !== want.clk_pin)
            report_mismatch("clk_pin", out_data.clk_pin, want.clk_pin);
          if (out_data.dq_out !== want.dq_out)
            report_mismatch("dq_out", out_data.dq_out, want.dq_out);
          if (out_data.dq_drive !== want.dq_drive)
            report_mismatch("dq_drive", out_data.dq_drive, want.dq_drive);
          if (out_data.busy_res !== want.busy_res)
            report_mismatch("busy_res", out_data.busy_res, want.busy_res);
          if (out_data.done_res !== want.done_res)
            report_mismatch("done_res", out_data.done_res, want.done_res);
          if (out_data.read_data !== want.read_data)
            report_mismatch("read_data", out_data.read_data, want.read_data);
          if (out_data.start_ignored !== want.start_ignored)
            report_mismatch("start_ignored", out_data.start_ignored, want.start_ignored);
        end
        words_seen++;
      end
      if (in_valid && !in_stall) begin
        pin_words.push_back(predict_tick(in_data));
        ticks_taken++;
      end
    end
  end

  always @(posedge clk) out_stall <= ($urandom_range(99, 0) < stall_pct);

  task automatic send_tick(input logic cmd, input logic [7:0] opc, input logic [2:0] mode,
                           input logic [8:0] wd, input logic dq);
    tws_in_t w;
    w.cmd = cmd;
    w.opcode = opc;
    w.data_mode = mode;
    w.write_data = wd;
    w.dq_in = dq;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
  endtask

  task automatic filler_tick(input logic cmd, input int dq_sel);
    send_tick(cmd, 8'($urandom_range(255, 0)), 3'($urandom_range(7, 0)),
              9'($urandom_range(511, 0)),
              (dq_sel == DQ_RANDOM) ? 1'($urandom_range(1, 0)) : 1'(dq_sel));
  endtask

  // Sends a start and exactly the ticks up to and including the finishing tick.
  task automatic run_transaction(input logic [7:0] opc, input logic [2:0] mode,
                                 input logic [8:0] wd, input int dq_sel, input int refuse_pct,
                                 input logic start_at_end);
    int len;
    len = ((cur_half == 0) ? 1 : cur_half) * (2 + 2 * (OPCODE_BITS + data_bits(mode)));
    send_tick(1'b1, opc, mode, wd, 1'($urandom_range(1, 0)));
    for (int i = 1; i <= len; i++)
      filler_tick((i == len) ? start_at_end : ($urandom_range(99, 0) < refuse_pct), dq_sel);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pin_words.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_half(input logic [15:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_half = v;
  endtask

  task automatic test_reset_state();
    repeat (4) filler_tick(1'b0, DQ_RANDOM);
    run_transaction(8'h55, MODE_NONE, 9'h0AA, DQ_RANDOM, 0, 1'b0);
    filler_tick(1'b0, DQ_RANDOM);
  endtask

  task automatic test_every_mode();
    write_half(16'd1);
    run_transaction(8'h00, MODE_NONE, 9'h000, DQ_LOW, 0, 1'b0);
    run_transaction(8'hFF, MODE_WR9, 9'h1FF, DQ_HIGH, 0, 1'b0);
    run_transaction(8'hA5, MODE_WR8, 9'h155, DQ_RANDOM, 0, 1'b0);
    run_transaction(8'h5A, MODE_RD8, 9'h0AA, DQ_HIGH, 0, 1'b0);
    repeat (2) filler_tick(1'b0, DQ_RANDOM);
    run_transaction(8'h3C, MODE_RD9, 9'h000, DQ_HIGH, 0, 1'b0);
    run_transaction(8'h81, MODE_RD9, 9'h1FF, DQ_RANDOM, 0, 1'b0);
    repeat (2) filler_tick(1'b0, DQ_RANDOM);
    for (int m = MODE_RD9 + 1; m < 8; m++)
      run_transaction(8'($urandom_range(255, 0)), 3'(m), 9'($urandom_range(511, 0)),
                      DQ_RANDOM, 0, 1'b0);
  endtask

  task automatic test_busy_starts();
    write_half(16'd2);
    run_transaction(8'($urandom_range(255, 0)), MODE_RD9, 9'($urandom_range(511, 0)),
                    DQ_RANDOM, 40, 1'b1);
    run_transaction(8'h0F, MODE_WR8, 9'h1AA, DQ_HIGH, 40, 1'b1);
    repeat (2) filler_tick(1'b0, DQ_RANDOM);
  endtask

  task automatic test_zero_half();
    write_half(16'd0);
    run_transaction(8'hC3, MODE_RD8, 9'h1FF, DQ_RANDOM, 0, 1'b0);
    filler_tick(1'b0, DQ_RANDOM);
  endtask

  // The half period is cut while a segment is already running.
  task automatic test_wait_shortened();
    write_half(16'hFFFF);
    send_tick(1'b1, 8'h96, MODE_WR9, 9'h0F3, 1'b0);
    repeat (20) filler_tick(1'b0, DQ_RANDOM);
    write_half(16'd1);
    repeat (40) filler_tick(1'b0, DQ_RANDOM);
    write_half(16'd10);
    send_tick(1'b1, 8'h69, MODE_RD9, 9'h000, 1'b1);
    repeat (15) filler_tick(1'b0, DQ_RANDOM);
    write_half(16'd2);
    repeat (80) filler_tick(1'b0, DQ_RANDOM);
  endtask

  task automatic test_random_traffic(input int send_pct, input int stall_in, input int n);
    int          first;
    int          pick;
    logic [2:0]  mode;
    write_half(16'($urandom_range(2, 0)));
    send_idle_pct = send_pct;
    stall_pct = stall_in;
    first = ticks_sent;
    while (ticks_sent - first < n) begin
      if ($urandom_range(7, 0) == 0) filler_tick(1'b0, DQ_RANDOM);
      pick = $urandom_range(15, 0);
      if (pick == 0) mode = MODE_NONE;
      else if (pick == 1) mode = 3'($urandom_range(7, MODE_RD9 + 1));
      else mode = 3'($urandom_range(MODE_RD9, MODE_WR8));
      run_transaction(8'($urandom_range(255, 0)), mode, 9'($urandom_range(511, 0)),
                      DQ_RANDOM, 5, $urandom_range(3, 0) == 0);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_stall <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_every_mode();
    test_busy_starts();
    test_zero_half();
    test_wait_shortened();
    test_random_traffic(0, 0, 50);
    test_random_traffic(88, 0, 50);
    test_random_traffic(0, 88, 50);
    test_random_traffic(11, 11, 50);

    drain_results();
    repeat (4) @(posedge clk);
    $display("Checked %0d result words for %0d ticks: %0d transactions, %0d refused starts.",
             words_seen, ticks_taken, starts_taken, starts_refused);
    $display("Half periods 0, 1, 2, 5, 10 and 65535 with cuts mid-segment, all data modes.");
    if (mismatches == 0 && pin_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
